// ----- hw/rtl/rcps_pkg.sv -----
// ----------------------------------------------------------------------------
// rcps_pkg: shared types and constants
// Word formats, result codes and sizes used by the residue class statistics
// block and its submodules.
// ----------------------------------------------------------------------------
package rcps_pkg;

  localparam int unsigned DEF_MAX_MODULUS = 1024;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned MOD_W     = 11;
  localparam int unsigned CLASS_W   = 10;
  localparam int unsigned COUNT_W   = 48;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_CNT_W = $clog2(VALUE_W);

  // command queue between front and back
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // input opcodes
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS     = 2'd0,
    REG_VALUE_LIMIT = 2'd1
  } reg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_LIMIT = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_ACC       = 2'd0,
    KIND_READ      = 2'd1,
    KIND_REJ_LIMIT = 2'd2,
    KIND_REJ_RANGE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [CLASS_W-1:0] cls;
    logic [MOD_W-1:0]   modulus;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [CLASS_W-1:0] residue;
    logic [COUNT_W-1:0] hit_count;
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] max_gap;
  } result_t;

endpackage

// ----- hw/rtl/rcps_front.sv -----
// ----------------------------------------------------------------------------
// rcps_front: input classification
// Resolves the effective modulus, checks the value limit and the class range
// and turns each accepted input word into a command for the back end.
// ----------------------------------------------------------------------------
module rcps_front #(
  parameter int unsigned MAX_MODULUS = rcps_pkg::DEF_MAX_MODULUS
) (
  input  logic                          opcode_i,
  input  logic [rcps_pkg::VALUE_W-1:0]  value_i,
  input  logic [rcps_pkg::CLASS_W-1:0]  class_index_i,
  input  logic [rcps_pkg::MOD_W-1:0]    modulus_i,
  input  logic [rcps_pkg::VALUE_W-1:0]  value_limit_i,
  output rcps_pkg::cmd_t                cmd_o
);

  logic [rcps_pkg::MOD_W-1:0] eff_mod;

  // zero acts as one, anything past the table depth is clamped
  always_comb begin
    if (modulus_i == '0) begin
      eff_mod = rcps_pkg::MOD_W'(1);
    end else if (32'(modulus_i) > MAX_MODULUS) begin
      eff_mod = rcps_pkg::MOD_W'(MAX_MODULUS);
    end else begin
      eff_mod = modulus_i;
    end
  end

  always_comb begin
    cmd_o.value   = value_i;
    cmd_o.cls     = class_index_i;
    cmd_o.modulus = eff_mod;
    if (opcode_i == rcps_pkg::OP_ACCUMULATE) begin
      cmd_o.kind = (value_i >= value_limit_i) ? rcps_pkg::KIND_REJ_LIMIT
                                              : rcps_pkg::KIND_ACC;
    end else begin
      cmd_o.kind = ({1'b0, class_index_i} >= eff_mod) ? rcps_pkg::KIND_REJ_RANGE
                                                      : rcps_pkg::KIND_READ;
    end
  end

endmodule

// ----- hw/rtl/rcps_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// rcps_cmd_fifo: command queue
// Short queue of classified commands that decouples the front from the back.
// ----------------------------------------------------------------------------
module rcps_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcps_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output rcps_pkg::cmd_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  rcps_pkg::cmd_t                     mem_q [rcps_pkg::CMD_DEPTH];
  logic [rcps_pkg::CMD_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [rcps_pkg::CMD_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [rcps_pkg::CMD_CNT_W-1:0]     cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign full_o  = (cnt_q == rcps_pkg::CMD_CNT_W'(rcps_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rcps_pkg::CMD_PTR_W'(rcps_pkg::CMD_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rcps_pkg::CMD_PTR_W'(rcps_pkg::CMD_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/rcps_div.sv -----
// ----------------------------------------------------------------------------
// rcps_div: serial divider
// Restoring division of a 64-bit value by the modulus, one quotient bit per
// cycle; results hold until the next start.
// ----------------------------------------------------------------------------
module rcps_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rcps_pkg::VALUE_W-1:0] dividend_i,
  input  logic [rcps_pkg::MOD_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [rcps_pkg::VALUE_W-1:0] quotient_o,
  output logic [rcps_pkg::MOD_W-1:0]   remainder_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [rcps_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [rcps_pkg::VALUE_W-1:0]   quo_q, quo_d;
  logic [rcps_pkg::MOD_W-1:0]     rem_q, rem_d;
  logic [rcps_pkg::MOD_W-1:0]     dvs_q, dvs_d;
  logic [rcps_pkg::MOD_W:0]       trial;
  logic                           fits;

  assign trial = {rem_q, quo_q[rcps_pkg::VALUE_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? rcps_pkg::MOD_W'(trial - {1'b0, dvs_q}) : trial[rcps_pkg::MOD_W-1:0];
      quo_d = {quo_q[rcps_pkg::VALUE_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rcps_pkg::DIV_CNT_W'(rcps_pkg::VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- hw/rtl/rcps_back.sv -----
// ----------------------------------------------------------------------------
// rcps_back: statistics engine
// Runs the divider, does the read-modify-write on the class tables and holds
// the result word until it is popped. Clears count and gap after reset.
// ----------------------------------------------------------------------------
module rcps_back #(
  parameter int unsigned MAX_MODULUS = rcps_pkg::DEF_MAX_MODULUS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcps_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output logic              clearing_o,
  output rcps_pkg::result_t res_o,
  output logic              res_valid_o,
  input  logic              res_pop_i
);

  localparam int unsigned IdxW = $clog2(MAX_MODULUS);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  localparam logic [rcps_pkg::COUNT_W-1:0] CountMax = '1;

  logic [2:0]                   state_q, state_d;
  logic [IdxW-1:0]              clr_q, clr_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  rcps_pkg::cmd_t               cmd_q, cmd_d;
  rcps_pkg::result_t            out_q, out_d;
  logic                         out_valid_q, out_valid_d;

  logic                         div_start, div_done;
  logic [rcps_pkg::VALUE_W-1:0] div_quo;
  logic [rcps_pkg::MOD_W-1:0]   div_rem;

  // class tables
  logic [rcps_pkg::COUNT_W-1:0] cnt_mem   [MAX_MODULUS];
  logic [rcps_pkg::VALUE_W-1:0] gap_mem   [MAX_MODULUS];
  logic [rcps_pkg::VALUE_W-1:0] first_mem [MAX_MODULUS];
  logic [rcps_pkg::VALUE_W-1:0] lastq_mem [MAX_MODULUS];
  logic [rcps_pkg::COUNT_W-1:0] cnt_rd_q;
  logic [rcps_pkg::VALUE_W-1:0] gap_rd_q, first_rd_q, lastq_rd_q;

  logic                         we_cg, we_fl;
  logic [IdxW-1:0]              wr_addr;
  logic [rcps_pkg::COUNT_W-1:0] cnt_wd;
  logic [rcps_pkg::VALUE_W-1:0] gap_wd, first_wd;

  logic [rcps_pkg::VALUE_W-1:0] step;

  // operands are taken straight from the queue head in the start cycle
  rcps_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (cmd_i.value),
    .divisor_i   (cmd_i.modulus),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign step = div_quo - lastq_rd_q;

  // updated statistics of the addressed class
  always_comb begin
    cnt_wd   = (cnt_rd_q == CountMax) ? cnt_rd_q : cnt_rd_q + 1'b1;
    first_wd = (cnt_rd_q == '0) ? cmd_q.value : first_rd_q;
    gap_wd   = gap_rd_q;
    if (cnt_rd_q != '0 && step > gap_rd_q) begin
      gap_wd = step;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_pop_i;
    cmd_pop_o   = 1'b0;
    div_start   = 1'b0;
    we_cg       = 1'b0;
    we_fl       = 1'b0;
    wr_addr     = idx_q;

    unique case (state_q)
      ST_CLR: begin
        we_cg   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IdxW'(MAX_MODULUS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          unique case (cmd_i.kind)
            rcps_pkg::KIND_ACC: begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
            rcps_pkg::KIND_READ: begin
              idx_d   = IdxW'(cmd_i.cls);
              state_d = ST_RD;
            end
            rcps_pkg::KIND_REJ_LIMIT: begin
              out_d       = '{status: rcps_pkg::STATUS_LIMIT, residue: '0,
                              hit_count: '0, first_value: '0, max_gap: '0};
              out_valid_d = 1'b1;
            end
            default: begin
              out_d       = '{status: rcps_pkg::STATUS_RANGE, residue: cmd_i.cls,
                              hit_count: '0, first_value: '0, max_gap: '0};
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          idx_d   = IdxW'(div_rem);
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (cmd_q.kind == rcps_pkg::KIND_ACC) begin
          we_cg = 1'b1;
          we_fl = 1'b1;
          out_d = '{status: rcps_pkg::STATUS_OK,
                    residue: rcps_pkg::CLASS_W'(div_rem),
                    hit_count: cnt_wd, first_value: first_wd, max_gap: gap_wd};
        end else begin
          out_d = '{status: rcps_pkg::STATUS_OK, residue: cmd_q.cls,
                    hit_count: cnt_rd_q,
                    first_value: (cnt_rd_q == '0) ? '0 : first_rd_q,
                    max_gap: gap_rd_q};
        end
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  // count and gap: cleared by the sweep, else written with the update
  always_ff @(posedge clk_i) begin
    if (we_cg) begin
      cnt_mem[wr_addr] <= (state_q == ST_CLR) ? '0 : cnt_wd;
      gap_mem[wr_addr] <= (state_q == ST_CLR) ? '0 : gap_wd;
    end
    cnt_rd_q <= cnt_mem[idx_q];
    gap_rd_q <= gap_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (we_fl) begin
      first_mem[wr_addr] <= first_wd;
      lastq_mem[wr_addr] <= div_quo;
    end
    first_rd_q <= first_mem[idx_q];
    lastq_rd_q <= lastq_mem[idx_q];
  end

  assign clearing_o  = (state_q == ST_CLR);
  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/residue_class_prime_statistics.sv -----
// ----------------------------------------------------------------------------
// residue_class_prime_statistics: per-class statistics of a value stream
// Top level: configuration registers, front classification, command queue
// and the statistics back end.
// ----------------------------------------------------------------------------
// usage
//   input words enter like a queue write: push with full low. opcode 0
//   accumulates value into class value mod modulus, opcode 1 reads the
//   statistics of class_index. each input word gives exactly one result word.
//   results leave like a queue read: while empty is low the oldest result is
//   on status/residue/hit_count/first_value/max_gap, pop takes it.
//   configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 modulus,
//   1 value limit) and cfg_data_i; write only while the block is idle.
// processing
//   accumulate: the serial divider works through all 64 quotient bits,
//   then a table read state and an update/write state follow
//   read: no division, just table read and update; rejected word: set in idle
//   one word is worked on at a time; a two-entry command queue keeps
//   accepting words while the back end is busy or a result waits
// reset
//   count and gap tables are swept to zero entry by entry after
//   reset; full stays high during the sweep, configuration writes are taken
// stall
//   a result not popped holds the back end; the queue fills, then full rises
// ----------------------------------------------------------------------------
module residue_class_prime_statistics #(
  parameter int unsigned MAX_MODULUS = rcps_pkg::DEF_MAX_MODULUS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input word channel
  input  logic                           push,
  output logic                           full,
  input  logic                           opcode_i,
  input  logic [rcps_pkg::VALUE_W-1:0]   value_i,
  input  logic [rcps_pkg::CLASS_W-1:0]   class_index_i,
  // result word channel
  output logic                           empty,
  input  logic                           pop,
  output logic [rcps_pkg::STATUS_W-1:0]  status_o,
  output logic [rcps_pkg::CLASS_W-1:0]   residue_o,
  output logic [rcps_pkg::COUNT_W-1:0]   hit_count_o,
  output logic [rcps_pkg::VALUE_W-1:0]   first_value_o,
  output logic [rcps_pkg::VALUE_W-1:0]   max_gap_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rcps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rcps_pkg::VALUE_W-1:0]   cfg_data_i
);

  logic [rcps_pkg::MOD_W-1:0]   modulus_q, modulus_d;
  logic [rcps_pkg::VALUE_W-1:0] limit_q, limit_d;

  rcps_pkg::cmd_t    front_cmd, fifo_cmd;
  logic              fifo_full, fifo_empty, fifo_pop;
  logic              clearing;
  rcps_pkg::result_t res;
  logic              res_valid;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_comb begin
    modulus_d = modulus_q;
    limit_d   = limit_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcps_pkg::REG_MODULUS:     modulus_d = cfg_data_i[rcps_pkg::MOD_W-1:0];
        rcps_pkg::REG_VALUE_LIMIT: limit_d   = cfg_data_i;
        default:                   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= rcps_pkg::MOD_W'(1);
      limit_q   <= '1;
    end else begin
      modulus_q <= modulus_d;
      limit_q   <= limit_d;
    end
  end

  // front: classify the word as it comes in
  rcps_front #(
    .MAX_MODULUS (MAX_MODULUS)
  ) u_front (
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .class_index_i (class_index_i),
    .modulus_i     (modulus_q),
    .value_limit_i (limit_q),
    .cmd_o         (front_cmd)
  );

  // no words taken while the tables are being cleared
  assign full = fifo_full || clearing;

  rcps_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .wdata_i (front_cmd),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // back: division, table update, result register
  rcps_back #(
    .MAX_MODULUS (MAX_MODULUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fifo_cmd),
    .cmd_valid_i (!fifo_empty),
    .cmd_pop_o   (fifo_pop),
    .clearing_o  (clearing),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty         = !res_valid;
  assign status_o      = res.status;
  assign residue_o     = res.residue;
  assign hit_count_o   = res.hit_count;
  assign first_value_o = res.first_value;
  assign max_gap_o     = res.max_gap;

  // no result word can exist before the table sweep is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (empty && fifo_empty))
    else $error("result or command present during table clear");

  // rejected words carry no statistics
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != rcps_pkg::STATUS_OK) |->
      (hit_count_o == '0 && first_value_o == '0 && max_gap_o == '0))
    else $error("rejected word carries statistics");

  // an empty class shows no first value and no gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && hit_count_o == '0) |-> (first_value_o == '0 && max_gap_o == '0))
    else $error("class with zero count shows data");

  // the back end only pops while the queue holds a command and no result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> (!fifo_empty && empty))
    else $error("command popped from empty queue or over a waiting result");

endmodule

// ----- tb/tb_residue_class_prime_statistics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_residue_class_prime_statistics: self-checking bench of the class stats
// Drives accumulate and read words through the queue-like ports, keeps its
// own per-class count, first value, last quotient and gap tables, and checks
// every result word against them in order. Runs a short directed sequence,
// then random phases under several modulus/limit settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_residue_class_prime_statistics;

  localparam int unsigned MAX_MODULUS   = rcps_pkg::DEF_MAX_MODULUS;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned REPORT_MAX    = 10;

  localparam logic [rcps_pkg::COUNT_W-1:0] COUNT_SAT  = '1;
  localparam logic [rcps_pkg::VALUE_W-1:0] VALUE_ONES = '1;

  // one input word as the bench keeps it
  typedef struct packed {
    logic                         op;
    logic [rcps_pkg::VALUE_W-1:0] value;
    logic [rcps_pkg::CLASS_W-1:0] cls;
  } stat_request_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           push          = 1'b0;
  logic                           full;
  logic                           opcode_i      = rcps_pkg::OP_ACCUMULATE;
  logic [rcps_pkg::VALUE_W-1:0]   value_i       = '0;
  logic [rcps_pkg::CLASS_W-1:0]   class_index_i = '0;
  logic                           empty;
  logic                           pop           = 1'b0;
  logic [rcps_pkg::STATUS_W-1:0]  status_o;
  logic [rcps_pkg::CLASS_W-1:0]   residue_o;
  logic [rcps_pkg::COUNT_W-1:0]   hit_count_o;
  logic [rcps_pkg::VALUE_W-1:0]   first_value_o;
  logic [rcps_pkg::VALUE_W-1:0]   max_gap_o;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [rcps_pkg::CFG_IDX_W-1:0] cfg_index_i   = rcps_pkg::REG_MODULUS;
  logic [rcps_pkg::VALUE_W-1:0]   cfg_data_i    = '0;

  // bench-side copy of the configuration and the class tables
  logic [rcps_pkg::MOD_W-1:0]   cfg_modulus;
  logic [rcps_pkg::VALUE_W-1:0] cfg_limit;
  logic [rcps_pkg::COUNT_W-1:0] count_tbl [MAX_MODULUS];
  logic [rcps_pkg::VALUE_W-1:0] first_tbl [MAX_MODULUS];
  logic [rcps_pkg::VALUE_W-1:0] lastq_tbl [MAX_MODULUS];
  logic [rcps_pkg::VALUE_W-1:0] gap_tbl   [MAX_MODULUS];

  stat_request_t     pending_requests [$];
  rcps_pkg::result_t expected_stats   [$];
  stat_request_t     next_req;

  logic        word_taken         = 1'b0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned fail_count         = 0;
  int unsigned cycle_count        = 0;

  residue_class_prime_statistics #(
    .MAX_MODULUS(MAX_MODULUS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .class_index_i (class_index_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .residue_o     (residue_o),
    .hit_count_o   (hit_count_o),
    .first_value_o (first_value_o),
    .max_gap_o     (max_gap_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // modulus zero acts as one, anything past the table depth saturates
  function automatic int unsigned eff_modulus();
    if (cfg_modulus == '0) return 1;
    if (32'(cfg_modulus) > MAX_MODULUS) return MAX_MODULUS;
    return 32'(cfg_modulus);
  endfunction

  // expected result word of one accepted input word; updates the tables
  function automatic rcps_pkg::result_t predict_stats(stat_request_t rq);
    rcps_pkg::result_t            res;
    logic [rcps_pkg::VALUE_W-1:0] m;
    logic [rcps_pkg::VALUE_W-1:0] rem;
    logic [rcps_pkg::VALUE_W-1:0] quo;
    logic [rcps_pkg::VALUE_W-1:0] step;
    int unsigned                  idx;
    m = rcps_pkg::VALUE_W'(eff_modulus());
    res = '0;
    res.status = rcps_pkg::STATUS_OK;
    if (rq.op == rcps_pkg::OP_ACCUMULATE) begin
      // at or over the limit: tables untouched, all fields zero
      if (rq.value >= cfg_limit) begin
        res.status = rcps_pkg::STATUS_LIMIT;
        return res;
      end
      rem = rq.value % m;
      quo = rq.value / m;
      idx = 32'(rem[rcps_pkg::CLASS_W-1:0]);
      if (count_tbl[idx] == '0) begin
        first_tbl[idx] = rq.value;
      end else begin
        // a falling quotient wraps modulo 2^64
        step = quo - lastq_tbl[idx];
        if (step > gap_tbl[idx]) gap_tbl[idx] = step;
      end
      if (count_tbl[idx] != COUNT_SAT) count_tbl[idx] = count_tbl[idx] + 1'b1;
      lastq_tbl[idx] = quo;
      res.residue = rem[rcps_pkg::CLASS_W-1:0];
    end else begin
      idx = 32'(rq.cls);
      res.residue = rq.cls;
      if (rcps_pkg::VALUE_W'(idx) >= m) begin
        res.status = rcps_pkg::STATUS_RANGE;
        return res;
      end
    end
    res.hit_count   = count_tbl[idx];
    res.first_value = (count_tbl[idx] != '0) ? first_tbl[idx] : '0;
    res.max_gap     = gap_tbl[idx];
    return res;
  endfunction

  // random word: mostly accumulates that land on a few busy classes with small
  // quotients so gaps build up, some near the limit, some full-range noise
  function automatic stat_request_t random_request();
    stat_request_t                rq;
    int unsigned                  m;
    int unsigned                  sel;
    int unsigned                  cls;
    logic [rcps_pkg::VALUE_W-1:0] quo;
    m = eff_modulus();
    sel = $urandom_range(0, 99);
    rq.value = {$urandom(), $urandom()};
    rq.cls = rcps_pkg::CLASS_W'($urandom_range(0, (1 << rcps_pkg::CLASS_W) - 1));
    if (sel < 25) begin
      rq.op = rcps_pkg::OP_READ;
      if ($urandom_range(0, 3) != 0) rq.cls = rcps_pkg::CLASS_W'($urandom_range(0, m - 1));
    end else begin
      rq.op = rcps_pkg::OP_ACCUMULATE;
      if (sel < 85) begin
        case ($urandom_range(0, 3))
          0: cls = m - 1;
          1: cls = $urandom_range(0, m - 1);
          default: cls = $urandom_range(0, (m < 8) ? m - 1 : 7);
        endcase
        quo = rcps_pkg::VALUE_W'($urandom_range(0, 3000));
        rq.value = quo * rcps_pkg::VALUE_W'(m) + rcps_pkg::VALUE_W'(cls);
      end else if (sel < 92 && cfg_limit > 2) begin
        rq.value = cfg_limit - rcps_pkg::VALUE_W'($urandom_range(0, 2));
      end
    end
    return rq;
  endfunction

  task automatic add_request(logic op, logic [rcps_pkg::VALUE_W-1:0] value,
                             logic [rcps_pkg::CLASS_W-1:0] cls);
    stat_request_t rq;
    rq.op = op;
    rq.value = value;
    rq.cls = cls;
    pending_requests.push_back(rq);
  endtask

  // wait until every queued word went in and every result word came back
  task automatic drain();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || push || expected_stats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(rcps_pkg::reg_idx_e idx, logic [rcps_pkg::VALUE_W-1:0] data);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == rcps_pkg::REG_MODULUS) cfg_modulus = data[rcps_pkg::MOD_W-1:0];
    else cfg_limit = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one random phase; halfway the sender holds until all results are back
  task automatic run_phase(int unsigned modulus, logic [rcps_pkg::VALUE_W-1:0] limit,
                           int unsigned idle_pct, int unsigned stall_pct, int unsigned n);
    logic [rcps_pkg::VALUE_W-1:0] mod_word;
    mod_word = {$urandom(), $urandom()};
    mod_word[rcps_pkg::MOD_W-1:0] = modulus[rcps_pkg::MOD_W-1:0];
    write_reg(rcps_pkg::REG_MODULUS, mod_word);
    write_reg(rcps_pkg::REG_VALUE_LIMIT, limit);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n / 2) pending_requests.push_back(random_request());
    drain();
    repeat (n - n / 2) pending_requests.push_back(random_request());
  endtask

  // sender and receiver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (!push || word_taken) begin
      if (rst_ni && pending_requests.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        next_req = pending_requests.pop_front();
        push          <= 1'b1;
        opcode_i      <= next_req.op;
        value_i       <= next_req.value;
        class_index_i <= next_req.cls;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // accepted input words feed the predictor, popped result words are checked
  always @(posedge clk_i) begin
    stat_request_t     rq;
    rcps_pkg::result_t got;
    rcps_pkg::result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      word_taken <= push && !full;
      if (push && !full) begin
        rq.op    = opcode_i;
        rq.value = value_i;
        rq.cls   = class_index_i;
        expected_stats.push_back(predict_stats(rq));
      end
      if (rst_ni && pop && !empty) begin
        got.status      = rcps_pkg::status_e'(status_o);
        got.residue     = residue_o;
        got.hit_count   = hit_count_o;
        got.first_value = first_value_o;
        got.max_gap     = max_gap_o;
        if (expected_stats.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: result word with nothing expected: st=%0d res=%0d", $realtime,
                     got.status, got.residue);
        end else begin
          want = expected_stats.pop_front();
          if (got.status !== want.status || got.residue !== want.residue ||
              got.hit_count !== want.hit_count || got.first_value !== want.first_value ||
              got.max_gap !== want.max_gap) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("%0t: stats mismatch", $realtime);
              $display("  exp st=%0d res=%0d cnt=%0h first=%0h gap=%0h", want.status,
                       want.residue, want.hit_count, want.first_value, want.max_gap);
              $display("  got st=%0d res=%0d cnt=%0h first=%0h gap=%0h", got.status,
                       got.residue, got.hit_count, got.first_value, got.max_gap);
            end
          end
        end
      end
    end
  end

  initial begin
    cfg_modulus = rcps_pkg::MOD_W'(1);
    cfg_limit   = VALUE_ONES;
    for (int i = 0; i < MAX_MODULUS; i++) begin
      count_tbl[i] = '0;
      first_tbl[i] = '0;
      lastq_tbl[i] = '0;
      gap_tbl[i]   = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: modulus 1, no limit short of all ones
    add_request(rcps_pkg::OP_ACCUMULATE, '0, '1);
    add_request(rcps_pkg::OP_ACCUMULATE, VALUE_ONES, '0);  // all ones sits at the limit
    add_request(rcps_pkg::OP_ACCUMULATE, 64'd5, '0);
    add_request(rcps_pkg::OP_READ, VALUE_ONES, '0);
    add_request(rcps_pkg::OP_READ, '0, 10'd1);             // class past the modulus
    add_request(rcps_pkg::OP_READ, '0, '1);

    // modulus zero acts as one; smaller quotient wraps the gap
    write_reg(rcps_pkg::REG_MODULUS, '0);
    add_request(rcps_pkg::OP_ACCUMULATE, 64'd3, '0);
    add_request(rcps_pkg::OP_READ, '0, '0);

    // oversized modulus saturates to the table depth, tight limit
    write_reg(rcps_pkg::REG_MODULUS, 64'd2047);
    write_reg(rcps_pkg::REG_VALUE_LIMIT, 64'd5000);
    add_request(rcps_pkg::OP_ACCUMULATE, 64'd1023, '0);
    add_request(rcps_pkg::OP_ACCUMULATE, 64'd1023 + 3 * 1024, '0);
    add_request(rcps_pkg::OP_ACCUMULATE, 64'd1023 + 1024, '0);
    add_request(rcps_pkg::OP_ACCUMULATE, 64'd5000, '0);
    add_request(rcps_pkg::OP_ACCUMULATE, 64'd4999, '0);
    add_request(rcps_pkg::OP_READ, '0, 10'd1023);
    add_request(rcps_pkg::OP_READ, '0, 10'd500);           // class never hit
    add_request(rcps_pkg::OP_READ, '0, 10'd903);

    // modulus just past the depth, limit zero rejects every accumulate
    write_reg(rcps_pkg::REG_MODULUS, 64'd1025);
    write_reg(rcps_pkg::REG_VALUE_LIMIT, '0);
    add_request(rcps_pkg::OP_ACCUMULATE, '0, '0);
    add_request(rcps_pkg::OP_READ, '0, 10'd1023);
    add_request(rcps_pkg::OP_READ, '0, 10'd0);

    run_phase(7, VALUE_ONES, 0, 0, 240);
    run_phase(1024, {$urandom(), $urandom()} >> 1, 54, 0, 260);
    run_phase(2, 64'd20000, 0, 54, 240);
    run_phase($urandom_range(2, MAX_MODULUS), VALUE_ONES, 35, 35, 260);
    run_phase(13, '0, 0, 0, 100);
    run_phase(2047, {$urandom(), $urandom()}, 35, 35, 150);
    run_phase(1, VALUE_ONES, 54, 54, 150);

    drain();
    if (expected_stats.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
